/* rtl/tbo_pkg.sv */
// ----------------------------------------------------------------------------
// tbo_pkg
// Shared widths, types and codes for the triangle / cube overlap test.
// ----------------------------------------------------------------------------
package tbo_pkg;

  localparam int COORD_BITS = 24;
  localparam int HALF_BITS  = COORD_BITS - 1;
  localparam int REL_BITS   = COORD_BITS + 1;
  localparam int EDGE_BITS  = COORD_BITS + 2;
  localparam int PROD_BITS  = EDGE_BITS + REL_BITS;
  localparam int PROJ_BITS  = PROD_BITS + 1;
  localparam int RSUM_BITS  = EDGE_BITS + 1;
  localparam int RAD_BITS   = RSUM_BITS + HALF_BITS;
  localparam int NPROD_BITS = 2 * EDGE_BITS;
  localparam int NORM_BITS  = NPROD_BITS + 1;
  localparam int NLO_BITS   = NORM_BITS / 2;
  localparam int NHI_BITS   = NORM_BITS - NLO_BITS;
  localparam int DLO_BITS   = NLO_BITS + 1 + REL_BITS;
  localparam int DHI_BITS   = NHI_BITS + REL_BITS;
  localparam int SABS_BITS  = NORM_BITS + 1;
  localparam int SLO_BITS   = SABS_BITS / 2;
  localparam int SHI_BITS   = SABS_BITS - SLO_BITS;
  localparam int RTOT_BITS  = SABS_BITS + HALF_BITS;
  localparam int DOT_BITS   = NORM_BITS + REL_BITS + 2;

  localparam int MIDQ_DEPTH    = 4;
  localparam int MIDQ_AW       = $clog2(MIDQ_DEPTH);
  localparam int OUTQ_DEPTH    = 16;
  localparam int OUTQ_AW       = $clog2(OUTQ_DEPTH);
  localparam int OUTQ_CNT_BITS = $clog2(OUTQ_DEPTH + 1);
  localparam int BACK_STAGES   = 7;

  // next and second-next axis, modulo three
  localparam int K1 [3] = '{1, 2, 0};
  localparam int K2 [3] = '{2, 0, 1};

  localparam logic [1:0] SLOT_UNUSED = 2'd3;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_TEST = 1'b1
  } op_t;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic        [HALF_BITS-1:0]  half_t;
  typedef logic signed [REL_BITS-1:0]   rel_t;
  typedef logic signed [EDGE_BITS-1:0]  edge_t;
  typedef logic        [EDGE_BITS-1:0]  edge_mag_t;
  typedef logic signed [PROD_BITS-1:0]  prod_t;
  typedef logic signed [PROJ_BITS-1:0]  proj_t;
  typedef logic        [RSUM_BITS-1:0]  rsum_t;
  typedef logic        [RAD_BITS-1:0]   rad_t;
  typedef logic signed [NPROD_BITS-1:0] nprod_t;
  typedef logic signed [NORM_BITS-1:0]  norm_t;
  typedef logic signed [DLO_BITS-1:0]   dlo_t;
  typedef logic signed [DHI_BITS-1:0]   dhi_t;
  typedef logic        [SABS_BITS-1:0]  sabs_t;
  typedef logic        [SLO_BITS+HALF_BITS-1:0] rlo_t;
  typedef logic        [SHI_BITS+HALF_BITS-1:0] rhi_t;
  typedef logic        [RTOT_BITS-1:0]  rtot_t;
  typedef logic signed [DOT_BITS-1:0]   dot_t;
  typedef logic        [OUTQ_CNT_BITS-1:0] ocnt_t;

  // one box test, vertices already taken relative to the cube centre
  typedef struct packed {
    logic [2:0][2:0][REL_BITS-1:0] v;
    half_t                         h;
  } test_item_t;

  typedef struct packed {
    logic valid;
    logic overlap;
  } result_t;

endpackage

/* rtl/tbo_front.sv */
// ----------------------------------------------------------------------------
// tbo_front
// Accepts items, keeps the triangle and turns box tests into relative vertices.
// ----------------------------------------------------------------------------
module tbo_front (
  input  logic                clk,
  input  logic                push,
  input  logic                op,
  input  logic [1:0]          slot,
  input  tbo_pkg::coord_t     cx,
  input  tbo_pkg::coord_t     cy,
  input  tbo_pkg::coord_t     cz,
  input  tbo_pkg::half_t      h,
  input  logic                q_full,
  output logic                q_push,
  output tbo_pkg::test_item_t q_item
);
  import tbo_pkg::*;

  coord_t tri_r [3][3];
  coord_t c [3];
  logic   accept;
  logic   load;

  assign accept = push && !q_full;
  assign load   = accept && (op_t'(op) == OP_LOAD) && (slot != SLOT_UNUSED);
  assign q_push = accept && (op_t'(op) == OP_TEST);

  always_ff @(posedge clk) begin
    if (load) begin
      tri_r[slot][0] <= cx;
      tri_r[slot][1] <= cy;
      tri_r[slot][2] <= cz;
    end
  end

  always_comb begin
    c[0] = cx;
    c[1] = cy;
    c[2] = cz;
    q_item.h = h;
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        q_item.v[i][k] = rel_t'(tri_r[i][k]) - rel_t'(c[k]);
      end
    end
  end

endmodule

/* rtl/tbo_midq.sv */
// ----------------------------------------------------------------------------
// tbo_midq
// Short queue of box tests between the front and the back pipeline.
// ----------------------------------------------------------------------------
module tbo_midq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  tbo_pkg::test_item_t din,
  input  logic                pop,
  output logic                full,
  output logic                empty,
  output tbo_pkg::test_item_t dout
);
  import tbo_pkg::*;

  test_item_t             mem_r [MIDQ_DEPTH];
  logic [MIDQ_AW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [MIDQ_AW:0]       cnt_r, cnt_nxt;

  assign full  = (cnt_r == (MIDQ_AW+1)'(MIDQ_DEPTH));
  assign empty = (cnt_r == '0);
  assign dout  = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r + (MIDQ_AW+1)'(push) - (MIDQ_AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= din;
  end

endmodule

/* rtl/tbo_back.sv */
// ----------------------------------------------------------------------------
// tbo_back
// Seven-stage separating-axis pipeline, issued on output queue credit.
// ----------------------------------------------------------------------------
module tbo_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  tbo_pkg::test_item_t q_item,
  input  tbo_pkg::ocnt_t      out_count,
  output logic                q_pop,
  output tbo_pkg::result_t    res
);
  import tbo_pkg::*;

  logic [BACK_STAGES-1:0] vld_r;
  ocnt_t                  infl_r, infl_nxt;
  logic                   issue;

  // stage 1
  rel_t      v_in [3][3];
  edge_t     e_nxt [3][3];
  edge_mag_t ae [3][3];
  rsum_t     rs_nxt [3][3];
  rel_t      hs, mn_b, mx_b;
  logic      bb_nxt;
  rel_t      v1_r [3][3];
  edge_t     e1_r [3][3];
  rsum_t     rs1_r [3][3];
  half_t     h1_r;
  logic      bb1_r;

  // stage 2
  prod_t  pe0_nxt [3][3][3];
  prod_t  pe1_nxt [3][3][3];
  nprod_t np0_nxt [3];
  nprod_t np1_nxt [3];
  rad_t   rad_nxt [3][3];
  prod_t  pe0_r [3][3][3];
  prod_t  pe1_r [3][3][3];
  nprod_t np0_r [3];
  nprod_t np1_r [3];
  rad_t   rad2_r [3][3];
  rel_t   v02_r [3];
  half_t  h2_r;
  logic   bb2_r;

  // stage 3
  proj_t proj_nxt [3][3][3];
  norm_t norm_nxt [3];
  proj_t proj_r [3][3][3];
  norm_t norm_r [3];
  rad_t  rad3_r [3][3];
  rel_t  v03_r [3];
  half_t h3_r;
  logic  bb3_r;

  // stage 4
  proj_t radp, mn_p, mx_p;
  logic  ef_nxt;
  dlo_t  dlo_nxt [3];
  dhi_t  dhi_nxt [3];
  sabs_t an [3];
  sabs_t sabs_nxt;
  dlo_t  dlo4_r [3];
  dhi_t  dhi4_r [3];
  sabs_t sabs4_r;
  half_t h4_r;
  logic  fail4_r;

  // stage 5
  rlo_t  rlo_nxt;
  rhi_t  rhi_nxt;
  dot_t  dk_nxt [3];
  rlo_t  rlo5_r;
  rhi_t  rhi5_r;
  dot_t  dk5_r [3];
  logic  fail5_r;

  // stage 6
  dot_t  d_nxt;
  rtot_t rtot_nxt;
  dot_t  d6_r;
  rtot_t rtot6_r;
  logic  fail6_r;

  // stage 7
  dot_t  rss;
  logic  ovl_nxt;
  logic  ovl7_r;

  assign issue = !q_empty &&
                 (({1'b0, out_count} + {1'b0, infl_r}) < (OUTQ_CNT_BITS+1)'(OUTQ_DEPTH));
  assign q_pop = issue;
  assign res.valid   = vld_r[BACK_STAGES-1];
  assign res.overlap = ovl7_r;

  always_comb begin
    infl_nxt = infl_r + ocnt_t'(issue) - ocnt_t'(res.valid);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      infl_r <= '0;
    end else begin
      vld_r  <= {vld_r[BACK_STAGES-2:0], issue};
      infl_r <= infl_nxt;
    end
  end

  // stage 1: edges, edge magnitudes, bounding box
  always_comb begin
    hs     = $signed({2'b00, q_item.h});
    bb_nxt = 1'b0;
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        v_in[i][k] = $signed(q_item.v[i][k]);
      end
    end
    for (int j = 0; j < 3; j++) begin
      for (int k = 0; k < 3; k++) begin
        e_nxt[j][k] = edge_t'(v_in[K1[j]][k]) - edge_t'(v_in[j][k]);
        ae[j][k]    = e_nxt[j][k][EDGE_BITS-1] ? EDGE_BITS'(-e_nxt[j][k])
                                               : EDGE_BITS'(e_nxt[j][k]);
      end
    end
    for (int j = 0; j < 3; j++) begin
      for (int k = 0; k < 3; k++) begin
        rs_nxt[j][k] = rsum_t'(ae[j][K1[k]]) + rsum_t'(ae[j][K2[k]]);
      end
    end
    for (int k = 0; k < 3; k++) begin
      mn_b = v_in[0][k];
      mx_b = v_in[0][k];
      for (int i = 1; i < 3; i++) begin
        if (v_in[i][k] < mn_b) mn_b = v_in[i][k];
        if (v_in[i][k] > mx_b) mx_b = v_in[i][k];
      end
      if ((mn_b > hs) || (mx_b < -hs)) bb_nxt = 1'b1;
    end
  end

  // stage 2: products
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      for (int k = 0; k < 3; k++) begin
        rad_nxt[j][k] = rs1_r[j][k] * h1_r;
        for (int i = 0; i < 3; i++) begin
          pe0_nxt[j][k][i] = e1_r[j][K1[k]] * v1_r[i][K2[k]];
          pe1_nxt[j][k][i] = e1_r[j][K2[k]] * v1_r[i][K1[k]];
        end
      end
    end
    for (int k = 0; k < 3; k++) begin
      np0_nxt[k] = e1_r[0][K1[k]] * e1_r[1][K2[k]];
      np1_nxt[k] = e1_r[0][K2[k]] * e1_r[1][K1[k]];
    end
  end

  // stage 3: projections and normal
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      for (int k = 0; k < 3; k++) begin
        for (int i = 0; i < 3; i++) begin
          proj_nxt[j][k][i] = proj_t'(pe0_r[j][k][i]) - proj_t'(pe1_r[j][k][i]);
        end
      end
    end
    for (int k = 0; k < 3; k++) begin
      norm_nxt[k] = norm_t'(np0_r[k]) - norm_t'(np1_r[k]);
    end
  end

  // stage 4: edge axes, split plane products, normal magnitude
  always_comb begin
    ef_nxt = bb3_r;
    for (int j = 0; j < 3; j++) begin
      for (int k = 0; k < 3; k++) begin
        radp = proj_t'(rad3_r[j][k]);
        mn_p = proj_r[j][k][0];
        mx_p = proj_r[j][k][0];
        for (int i = 1; i < 3; i++) begin
          if (proj_r[j][k][i] < mn_p) mn_p = proj_r[j][k][i];
          if (proj_r[j][k][i] > mx_p) mx_p = proj_r[j][k][i];
        end
        if ((radp < mn_p) || (mx_p < -radp)) ef_nxt = 1'b1;
      end
    end
    for (int k = 0; k < 3; k++) begin
      dlo_nxt[k] = $signed({1'b0, norm_r[k][NLO_BITS-1:0]}) * v03_r[k];
      dhi_nxt[k] = $signed(norm_r[k][NORM_BITS-1:NLO_BITS]) * v03_r[k];
      an[k]      = norm_r[k][NORM_BITS-1] ? sabs_t'(-norm_r[k]) : sabs_t'(norm_r[k]);
    end
    sabs_nxt = an[0] + an[1] + an[2];
  end

  // stage 5: radius partials, per-axis dot terms
  always_comb begin
    rlo_nxt = sabs4_r[SLO_BITS-1:0] * h4_r;
    rhi_nxt = sabs4_r[SABS_BITS-1:SLO_BITS] * h4_r;
    for (int k = 0; k < 3; k++) begin
      dk_nxt[k] = (dot_t'(dhi4_r[k]) <<< NLO_BITS) + dot_t'(dlo4_r[k]);
    end
  end

  // stage 6: plane distance and radius
  always_comb begin
    d_nxt    = dk5_r[0] + dk5_r[1] + dk5_r[2];
    rtot_nxt = (rtot_t'(rhi5_r) << SLO_BITS) + rtot_t'(rlo5_r);
  end

  // stage 7: plane test
  always_comb begin
    rss     = dot_t'(rtot6_r);
    ovl_nxt = !(fail6_r || (d6_r < -rss) || (d6_r > rss));
  end

  always_ff @(posedge clk) begin
    v1_r    <= v_in;
    e1_r    <= e_nxt;
    rs1_r   <= rs_nxt;
    h1_r    <= q_item.h;
    bb1_r   <= bb_nxt;

    pe0_r   <= pe0_nxt;
    pe1_r   <= pe1_nxt;
    np0_r   <= np0_nxt;
    np1_r   <= np1_nxt;
    rad2_r  <= rad_nxt;
    v02_r   <= v1_r[0];
    h2_r    <= h1_r;
    bb2_r   <= bb1_r;

    proj_r  <= proj_nxt;
    norm_r  <= norm_nxt;
    rad3_r  <= rad2_r;
    v03_r   <= v02_r;
    h3_r    <= h2_r;
    bb3_r   <= bb2_r;

    dlo4_r  <= dlo_nxt;
    dhi4_r  <= dhi_nxt;
    sabs4_r <= sabs_nxt;
    h4_r    <= h3_r;
    fail4_r <= ef_nxt;

    rlo5_r  <= rlo_nxt;
    rhi5_r  <= rhi_nxt;
    dk5_r   <= dk_nxt;
    fail5_r <= fail4_r;

    d6_r    <= d_nxt;
    rtot6_r <= rtot_nxt;
    fail6_r <= fail5_r;

    ovl7_r  <= ovl_nxt;
  end

endmodule

/* rtl/tbo_outq.sv */
// ----------------------------------------------------------------------------
// tbo_outq
// Result queue; its fill count feeds the back pipeline's issue credit.
// ----------------------------------------------------------------------------
module tbo_outq (
  input  logic             clk,
  input  logic             rst_n,
  input  tbo_pkg::result_t res,
  input  logic             pop,
  output logic             empty,
  output logic             dout,
  output tbo_pkg::ocnt_t   count
);
  import tbo_pkg::*;

  logic [OUTQ_DEPTH-1:0] mem_r;
  logic [OUTQ_AW-1:0]    wr_ptr_r, rd_ptr_r;
  ocnt_t                 cnt_r, cnt_nxt;
  logic                  do_pop;

  assign empty  = (cnt_r == '0);
  assign do_pop = pop && !empty;
  assign dout   = mem_r[rd_ptr_r];
  assign count  = cnt_r;

  always_comb begin
    cnt_nxt = cnt_r + ocnt_t'(res.valid) - ocnt_t'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (res.valid) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)    rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) mem_r[wr_ptr_r] <= res.overlap;
  end

endmodule

/* rtl/triangle_box_overlap_test.sv */
// ----------------------------------------------------------------------------
// triangle_box_overlap_test
// Triangle against axis-aligned cube overlap test, one test per cycle while the result queue has room.
// ----------------------------------------------------------------------------
// Input queue: push with in_full low accepts an item. A load item (operation
// 0) writes vertex in_vertex_slot (slot 3 is ignored) and gives no result. A
// test item (operation 1) gives a cube centre and half size and returns one
// overlap bit; it sees every load accepted before it, none after.
// Result queue: out_overlap is valid while out_empty is low; pop takes it.
// A test passes through the front queue and then the back pipeline, whose
// depth is set by the split 80-bit plane dot product. Throughput is one item
// per cycle while the result queue has room.
// Tests issue only while the 16-entry result queue has room for everything in
// flight, so a stalled receiver backs up the 4-entry front queue and then
// raises in_full; nothing is lost.
// Reset clears both queues and the pipeline; the stored vertices are not
// cleared, so all three must be loaded before the first test.
// ----------------------------------------------------------------------------
module triangle_box_overlap_test (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  output logic                  in_full,
  input  logic [0:0]            in_operation,
  input  logic [1:0]            in_vertex_slot,
  input  tbo_pkg::coord_t       in_coord_x,
  input  tbo_pkg::coord_t       in_coord_y,
  input  tbo_pkg::coord_t       in_coord_z,
  input  tbo_pkg::half_t        in_half_size,
  output logic                  out_empty,
  input  logic                  out_pop,
  output logic [0:0]            out_overlap
);
  import tbo_pkg::*;

  logic       q_push, q_pop, q_empty;
  test_item_t q_in, q_out;
  result_t    res;
  ocnt_t      out_count;

  tbo_front u_front (
    .clk    (clk),
    .push   (in_push),
    .op     (in_operation[0]),
    .slot   (in_vertex_slot),
    .cx     (in_coord_x),
    .cy     (in_coord_y),
    .cz     (in_coord_z),
    .h      (in_half_size),
    .q_full (in_full),
    .q_push (q_push),
    .q_item (q_in)
  );

  tbo_midq u_midq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_in),
    .pop   (q_pop),
    .full  (in_full),
    .empty (q_empty),
    .dout  (q_out)
  );

  tbo_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_item    (q_out),
    .out_count (out_count),
    .q_pop     (q_pop),
    .res       (res)
  );

  tbo_outq u_outq (
    .clk   (clk),
    .rst_n (rst_n),
    .res   (res),
    .pop   (out_pop),
    .empty (out_empty),
    .dout  (out_overlap[0]),
    .count (out_count)
  );

  // a result never arrives at a full result queue
  assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> (out_count < ocnt_t'(OUTQ_DEPTH)))
    else $error("result pushed into full result queue");

  // the back pipeline only takes from a non-empty front queue
  assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("pop from empty front queue");

  // an accepted test shows up in the front queue on the next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && !q_pop) |=> !q_empty)
    else $error("accepted test missing from front queue");

endmodule
